// ===== sv/rsce_pkg.sv =====
package rsce_pkg;

	localparam logic       KIND_START = 1'b0;
	localparam logic       KIND_DATA  = 1'b1;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int         PREFIX_LEN     = 5;
	localparam logic [3:0] LINE_MIN_LF_POS = 4'd12;
	localparam logic [3:0] CODE_START_POS  = 4'd9;
	localparam logic [3:0] POS_MAX         = 4'd15;

	localparam logic [1:0] TRIM_KEEP_ALL   = 2'd0;
	localparam logic [1:0] TRIM_DROP_THIRD = 2'd1;
	localparam logic [1:0] TRIM_DROP_REPEAT = 2'd2;
	localparam logic [1:0] TRIM_RESET      = TRIM_DROP_THIRD;

	// number scan phases
	localparam logic [1:0] SCAN_BLANK  = 2'd0;
	localparam logic [1:0] SCAN_DIGITS = 2'd1;
	localparam logic [1:0] SCAN_DONE   = 2'd2;

	typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;
	localparam prefix_t PREFIX = {8'h2F, 8'h50, 8'h53, 8'h54, 8'h52};

	typedef logic [2:0][7:0] code_chars_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic signed [10:0] code;
		logic               kept;
	} out_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// atoi over the three code bytes; the window bounds the value to -99..999
	function automatic logic signed [10:0] read_number(input code_chars_t chars);
		logic [1:0] phase;
		logic       neg;
		logic [9:0] val;
		logic [7:0] c;
		logic [7:0] d;
		phase = SCAN_BLANK;
		neg   = 1'b0;
		val   = '0;
		for (int k = 0; k < 3; k++) begin
			c = chars[2'(k)];
			d = c - CHAR_ZERO;
			unique case (phase)
				SCAN_BLANK: begin
					if (is_blank(c)) begin
						phase = SCAN_BLANK;
					end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
						neg   = (c == CHAR_MINUS);
						phase = SCAN_DIGITS;
					end else if (is_digit(c)) begin
						val   = {6'd0, d[3:0]};
						phase = SCAN_DIGITS;
					end else begin
						phase = SCAN_DONE;
					end
				end
				SCAN_DIGITS: begin
					if (is_digit(c)) begin
						val = val * 10'd10 + {6'd0, d[3:0]};
					end else begin
						phase = SCAN_DONE;
					end
				end
				default: begin
					phase = SCAN_DONE;
				end
			endcase
		end
		return neg ? -$signed({1'b0, val}) : $signed({1'b0, val});
	endfunction

endpackage

// ===== sv/rtsp_status_code_extractor.sv =====
// RTSP status-line code extractor.
// Input channel (in_valid/in_ready/in_data): one beat per start marker or stream byte.
// A start beat clears all line and trim history and yields code 0, kept 1.
// A data beat that ends a line (CR LF) of 13+ bytes starting with "RTSP/" yields
// the atoi value of bytes 9..11; a zero value halts output until the next start.
// Each code carries a kept flag from the repeat rule (0 keep all, 1 drop a value
// equal to both of the last two kept, 2 drop a value equal to the last kept).
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the repeat rule; write it
// only while idle. cfg_ready is always high.
// An accepted beat is held in the input register; its result then goes to the
// output register on out_valid. Throughput: one beat per cycle while out drains,
// set by the single input register feeding parse/trim and the output register.
// When out_ready is low the output register holds its beat; one more input beat
// is taken into the input register, then in_ready drops until out drains.
// Reset (arst_n low, asynchronous) empties both registers, clears line and trim
// history, and sets the repeat rule to 1.
module rtsp_status_code_extractor (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rsce_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rsce_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_data
);
	import rsce_pkg::*;

	in_t                in_s1;
	logic               valid_s1;
	out_t               out_q;
	logic               out_valid_q;
	logic [1:0]         repeat_rule_q;

	logic [3:0]         line_pos_q;
	logic               prev_cr_q;
	logic               prefix_ok_q;
	code_chars_t        code_chars_q;
	logic               halted_q;
	logic signed [10:0] recent0_q;
	logic signed [10:0] recent1_q;
	logic [1:0]         kept_count_q;

	logic               fire_s1;
	logic               is_lf_end;
	logic               line_full;
	logic signed [10:0] value;
	logic               keep;
	logic               emit;
	out_t               result;

	assign cfg_ready = 1'b1;
	assign fire_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_lf_end = (line_pos_q != 4'd0) && prev_cr_q && (in_s1.data_byte == CHAR_LF);
	assign line_full = (line_pos_q >= LINE_MIN_LF_POS) && prefix_ok_q;
	assign value     = read_number(code_chars_q);

	always_comb begin
		keep = 1'b1;
		unique case (repeat_rule_q)
			TRIM_DROP_THIRD: begin
				if (kept_count_q == 2'd2 && recent0_q == value && recent1_q == value) begin
					keep = 1'b0;
				end
			end
			TRIM_DROP_REPEAT: begin
				if (kept_count_q != 2'd0 && recent0_q == value) begin
					keep = 1'b0;
				end
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	always_comb begin
		emit        = 1'b0;
		result.code = value;
		result.kept = keep;
		if (in_s1.kind == KIND_START) begin
			emit        = 1'b1;
			result.code = '0;
			result.kept = 1'b1;
		end else if (!halted_q && is_lf_end && line_full && value != 11'sd0) begin
			emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_rule_q <= TRIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repeat_rule_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q   <= '0;
			prev_cr_q    <= 1'b0;
			prefix_ok_q  <= 1'b1;
			code_chars_q <= '0;
			halted_q     <= 1'b0;
			recent0_q    <= '0;
			recent1_q    <= '0;
			kept_count_q <= '0;
		end else if (fire_s1) begin
			if (in_s1.kind == KIND_START) begin
				line_pos_q   <= '0;
				prev_cr_q    <= 1'b0;
				prefix_ok_q  <= 1'b1;
				code_chars_q <= '0;
				halted_q     <= 1'b0;
				recent0_q    <= '0;
				recent1_q    <= '0;
				kept_count_q <= 2'd1;
			end else if (!halted_q) begin
				if (is_lf_end) begin
					line_pos_q  <= '0;
					prev_cr_q   <= 1'b0;
					prefix_ok_q <= 1'b1;
					if (line_full) begin
						if (value == 11'sd0) begin
							halted_q <= 1'b1;
						end else if (keep) begin
							recent1_q <= recent0_q;
							recent0_q <= value;
							if (kept_count_q != 2'd2) begin
								kept_count_q <= kept_count_q + 2'd1;
							end
						end
					end
				end else begin
					if (line_pos_q < 4'(PREFIX_LEN)
					    && in_s1.data_byte != PREFIX[line_pos_q[2:0]]) begin
						prefix_ok_q <= 1'b0;
					end
					if (line_pos_q >= CODE_START_POS && line_pos_q < CODE_START_POS + 4'd3) begin
						code_chars_q[2'(line_pos_q - CODE_START_POS)] <= in_s1.data_byte;
					end
					prev_cr_q <= (in_s1.data_byte == CHAR_CR);
					if (line_pos_q != POS_MAX) begin
						line_pos_q <= line_pos_q + 4'd1;
					end
				end
			end
		end
	end

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled while output side could advance");

	a_start_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && in_s1.kind == KIND_START) |=>
		(out_valid_q && out_q.code == 11'sd0 && out_q.kept && kept_count_q == 2'd1))
		else $error("start beat did not yield code 0 with fresh history");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && in_s1.kind == KIND_DATA && halted_q) |=> (!out_valid_q && halted_q))
		else $error("halted block produced a result or left halt on data");

	a_kept_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q != 2'd3)
		else $error("trim history count overflow");

endmodule
